[hdl/srem_pkg.sv]
// shared types and constants for the signed remainder pipeline
package srem_pkg;

    localparam int FIELD_WIDTH = 64;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] numerator;
        logic signed [FIELD_WIDTH-1:0] denominator;
    } operand_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] remainder;
        logic                          divide_by_zero;
    } result_t;

endpackage

[hdl/signed_remainder_64.sv]
// pipelined signed truncating remainder, one restoring step per stage
//
//   channel | signals                  | direction | payload
//   --------+--------------------------+-----------+-------------------------------
//   op      | op_valid, op_ready, op   | in        | operand_t: numerator, denominator
//   res     | res_valid, res_ready, res| out       | result_t: remainder, divide_by_zero
//
// the pipeline is an input register, one stage per quotient bit (one
// (DATA_WIDTH+1)-bit subtract each), and a sign-fix output register.
// a new pair is taken every cycle while res is not stalled.
// a stall at res (res_valid high, res_ready low) freezes every stage and drops op_ready.
// reset clears the valid bits only; the data registers are not reset.
module signed_remainder_64
    import srem_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     op_valid,
    output logic     op_ready,
    input  operand_t op,
    output logic     res_valid,
    input  logic     res_ready,
    output result_t  res
);

    localparam int W = DATA_WIDTH;

    logic         advance;
    logic         valid_reg [0:W];
    logic         neg_reg   [0:W];
    logic         dz_reg    [0:W];
    logic [W-1:0] rem_reg   [0:W];
    logic [W-1:0] num_reg   [0:W-1];
    logic [W-1:0] den_reg   [0:W-1];
    logic [W-1:0] rem_next  [1:W];

    logic [W-1:0] num_in;
    logic [W-1:0] den_in;
    logic [W-1:0] fixed_rem;
    result_t      res_reg;
    result_t      res_next;
    logic         res_valid_reg;

    assign advance  = !(res_valid_reg && !res_ready);
    assign op_ready = advance;
    assign num_in   = op.numerator[W-1:0];
    assign den_in   = op.denominator[W-1:0];

    // per-stage restoring step; a zero divisor just accumulates |numerator|
    for (genvar k = 1; k <= W; k++) begin : g_step
        logic [W:0]   rem_shift;
        logic [W+1:0] diff;

        always_comb
        begin
            rem_shift   = {rem_reg[k-1], num_reg[k-1][W-1]};
            diff        = {1'b0, rem_shift} - {2'b00, den_reg[k-1]};
            rem_next[k] = diff[W+1] ? rem_shift[W-1:0] : diff[W-1:0];
        end
    end

    always_comb
    begin
        fixed_rem               = neg_reg[W] ? (~rem_reg[W] + 1'b1) : rem_reg[W];
        res_next.remainder      = FIELD_WIDTH'(signed'(fixed_rem));
        res_next.divide_by_zero = dz_reg[W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= W; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= op_valid;
            for (int k = 1; k <= W; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
            res_valid_reg <= valid_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            neg_reg[0] <= num_in[W-1];
            dz_reg[0]  <= (den_in == '0);
            rem_reg[0] <= '0;
            num_reg[0] <= num_in[W-1] ? (~num_in + 1'b1) : num_in;
            den_reg[0] <= den_in[W-1] ? (~den_in + 1'b1) : den_in;
            for (int k = 1; k <= W; k++)
            begin
                neg_reg[k] <= neg_reg[k-1];
                dz_reg[k]  <= dz_reg[k-1];
                rem_reg[k] <= rem_next[k];
            end
            // the last stage needs no dividend bits or divisor
            for (int k = 1; k < W; k++)
            begin
                num_reg[k] <= {num_reg[k-1][W-2:0], 1'b0};
                den_reg[k] <= den_reg[k-1];
            end
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[hdl/srem_checker.sv]
// port-level checks for the signed remainder pipeline, bound to the top level
module srem_checker
    import srem_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input logic     clk,
    input logic     rst_n,
    input logic     op_valid,
    input logic     op_ready,
    input operand_t op,
    input logic     res_valid,
    input logic     res_ready,
    input result_t  res
);

    // a waiting input transfer holds
    a_op_hold: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && !op_ready |=> op_valid && $stable(op))
        else $error("operands changed while waiting");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // a ready sink never blocks the source
    a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> op_ready)
        else $error("input blocked while output ready");

    // a stalled output freezes the pipe, so no transfer can enter
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !op_ready)
        else $error("input taken during output stall");

    // remainder is a sign-extended DATA_WIDTH-bit value
    a_sext: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((&res.remainder[FIELD_WIDTH-1:DATA_WIDTH-1])
                    || !(|res.remainder[FIELD_WIDTH-1:DATA_WIDTH-1])))
        else $error("remainder not sign-extended");

endmodule

bind signed_remainder_64 srem_checker #(.DATA_WIDTH(DATA_WIDTH)) u_srem_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
